/* sv/wsfd_pkg.sv */
// package for the websocket frame deframer: types, constants and codes
package wsfd_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       fin_flag;
        logic [2:0] reserved_bits;
        logic [3:0] frame_opcode;
        logic       was_masked;
        logic       empty_frame;
        logic       frame_last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_push;

endpackage

/* sv/wsfd_ifs.sv */
// stream interfaces for received bytes and parsed results
interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       fin_flag;
    logic [2:0] reserved_bits;
    logic [3:0] frame_opcode;
    logic       was_masked;
    logic       empty_frame;
    logic       frame_last;

    modport source (
        output valid, output payload_byte, output fin_flag, output reserved_bits,
        output frame_opcode, output was_masked, output empty_frame, output frame_last,
        input ready
    );
    modport sink (
        input valid, input payload_byte, input fin_flag, input reserved_bits,
        input frame_opcode, input was_masked, input empty_frame, input frame_last,
        output ready
    );
endinterface

/* sv/websocket_frame_deframer_core.sv */
// websocket frame deframer top level: parser feeding a two-entry output buffer
// results are registered in the main entry, or the skid entry while main waits
// throughput: one received byte per cycle, sustained while the result sink keeps up
// the buffer holds a second result while the first waits, then stalls the input
// reset: synchronous active low, parser returns to the first header byte, buffer empties
module websocket_frame_deframer_core #(
    parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsfd_in_if.sink    i_in,
    wsfd_out_if.source o_out
);
    import wsfd_pkg::*;

    t_res_push w_push;
    logic      w_buf_ready;
    logic      w_accept;

    assign i_in.ready = w_buf_ready;
    assign w_accept   = i_in.valid && w_buf_ready;

    wsfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_in.rx_byte),
        .o_push    (w_push)
    );

    wsfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_buf_ready),
        .o_out   (o_out)
    );

endmodule

/* sv/wsfd_parser.sv */
// frame header parser, length and key capture, payload unmasking
module wsfd_parser #(
    parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    output wsfd_pkg::t_res_push o_push
);
    import wsfd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [7:0]             r_hdr0, n_hdr0;
    logic                   r_mask, n_mask;
    logic [3:0]             r_left, n_left;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [31:0]            r_key, n_key;
    logic [1:0]             r_pos, n_pos;

    logic [6:0]             w_len7;
    logic [LENGTH_BITS-1:0] w_ext_len;
    logic [7:0]             w_key_byte;

    assign w_len7    = i_rx_byte[6:0];
    assign w_ext_len = {r_len[LENGTH_BITS-9:0], i_rx_byte};

    always_comb begin
        unique case (r_pos)
            2'd0: w_key_byte = r_key[31:24];
            2'd1: w_key_byte = r_key[23:16];
            2'd2: w_key_byte = r_key[15:8];
            2'd3: w_key_byte = r_key[7:0];
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hdr0  = r_hdr0;
        n_mask  = r_mask;
        n_left  = r_left;
        n_len   = r_len;
        n_key   = r_key;
        n_pos   = r_pos;
        if (i_accept) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_mask = i_rx_byte[7];
                    n_pos  = '0;
                    if (w_len7 == LEN_CODE_16) begin
                        n_phase = PH_EXTLEN;
                        n_left  = EXT16_BYTES;
                        n_len   = '0;
                    end else if (w_len7 == LEN_CODE_64) begin
                        n_phase = PH_EXTLEN;
                        n_left  = EXT64_BYTES;
                        n_len   = '0;
                    end else begin
                        n_len = LENGTH_BITS'(w_len7);
                        if (i_rx_byte[7]) begin
                            n_phase = PH_KEY;
                            n_left  = KEY_BYTES;
                        end else if (w_len7 == '0) begin
                            n_phase = PH_HDR0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_len  = w_ext_len;
                    n_left = 4'(r_left - 4'd1);
                    n_pos  = '0;
                    if (r_left == 4'd1) begin
                        if (r_mask) begin
                            n_phase = PH_KEY;
                            n_left  = KEY_BYTES;
                        end else if (w_ext_len == '0) begin
                            n_phase = PH_HDR0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_KEY: begin
                    n_key  = {r_key[23:0], i_rx_byte};
                    n_left = 4'(r_left - 4'd1);
                    n_pos  = '0;
                    if (r_left == 4'd1) begin
                        n_phase = (r_len == '0) ? PH_HDR0 : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_len = LENGTH_BITS'(r_len - 1'b1);
                    n_pos = 2'(r_pos + 2'd1);
                    if (r_len == LENGTH_BITS'(1)) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_hdr0  = i_rx_byte;
                    n_phase = PH_HDR1;
                end
            endcase
        end
    end

    // result outputs
    always_comb begin
        o_push.valid             = 1'b0;
        o_push.res.payload_byte  = '0;
        o_push.res.fin_flag      = r_hdr0[7];
        o_push.res.reserved_bits = r_hdr0[6:4];
        o_push.res.frame_opcode  = r_hdr0[3:0];
        o_push.res.was_masked    = r_mask;
        o_push.res.empty_frame   = 1'b1;
        o_push.res.frame_last    = 1'b1;
        if (i_accept) begin
            unique case (r_phase)
                PH_HDR1: begin
                    o_push.res.was_masked = i_rx_byte[7];
                    o_push.valid = !i_rx_byte[7] && (w_len7 == '0);
                end
                PH_EXTLEN: begin
                    o_push.valid = (r_left == 4'd1) && !r_mask && (w_ext_len == '0);
                end
                PH_KEY: begin
                    o_push.valid = (r_left == 4'd1) && (r_len == '0);
                end
                PH_PAYLOAD: begin
                    o_push.valid            = 1'b1;
                    o_push.res.empty_frame  = 1'b0;
                    o_push.res.frame_last   = (r_len == LENGTH_BITS'(1));
                    o_push.res.payload_byte = r_mask ? (i_rx_byte ^ w_key_byte) : i_rx_byte;
                end
                default: begin
                    o_push.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_hdr0  <= '0;
            r_mask  <= 1'b0;
            r_left  <= '0;
            r_len   <= '0;
            r_key   <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hdr0  <= n_hdr0;
            r_mask  <= n_mask;
            r_left  <= n_left;
            r_len   <= n_len;
            r_key   <= n_key;
            r_pos   <= n_pos;
        end
    end

`ifndef SYNTH
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_accept)
        else $error("result pushed without an accepted byte");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.res.empty_frame) |-> o_push.res.frame_last)
        else $error("empty frame result not marked last");
    a_payload_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_len != '0))
        else $error("payload phase with no bytes left");
    a_last_returns_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.res.frame_last) |=> (r_phase == PH_HDR0))
        else $error("frame ended without returning to header phase");
`endif

endmodule

/* sv/wsfd_out_buf.sv */
// two-entry output buffer that holds results while the sink stalls
module wsfd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsfd_pkg::t_res_push i_push,
    output logic                o_ready,
    wsfd_out_if.source          o_out
);
    import wsfd_pkg::*;

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    w_pop;

    assign w_pop   = r_main_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push.valid;
                r_main       <= i_push.res;
            end
        end else if (i_push.valid) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
                r_main       <= i_push.res;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_push.res;
            end
        end
    end

    assign o_out.valid         = r_main_valid;
    assign o_out.payload_byte  = r_main.payload_byte;
    assign o_out.fin_flag      = r_main.fin_flag;
    assign o_out.reserved_bits = r_main.reserved_bits;
    assign o_out.frame_opcode  = r_main.frame_opcode;
    assign o_out.was_masked    = r_main.was_masked;
    assign o_out.empty_frame   = r_main.empty_frame;
    assign o_out.frame_last    = r_main.frame_last;

`ifndef SYNTH
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without a main entry");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push.valid)
        else $error("result pushed into a full buffer");
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && r_main_valid && !w_pop) |=> r_skid_valid)
        else $error("stalled result not captured in skid entry");
`endif

endmodule
